/* hw/rtl/cas_pkg.sv */
// cas_pkg: shared types, constants and phase timing for the condition alarm sequencer
// used by cas_core and condition_alarm_sequencer_top; no dependencies

package cas_pkg;

  localparam int NUM_COND  = 6;
  localparam int LIMIT_W   = 8;
  localparam int SEQ_W     = 3;
  localparam int SECS_W    = 4;
  localparam int CFG_IDX_W = 3;

  localparam logic [SECS_W-1:0] SECS_MAX      = 4'd15;
  localparam logic [SECS_W-1:0] DUR_WAIT_ONE  = 4'd2;
  localparam logic [SECS_W-1:0] DUR_WAIT      = 4'd3;
  localparam logic [SECS_W-1:0] DUR_BUZZ_LONG = 4'd7;
  localparam logic [SECS_W-1:0] DUR_BUZZ      = 4'd5;
  localparam logic [SECS_W-1:0] DUR_RELAY     = 4'd10;
  localparam logic [SECS_W-1:0] DUR_UNTIMED   = 4'd0;

  localparam logic [SEQ_W-1:0] SEQ_NONE  = 3'd0;
  localparam logic [SEQ_W-1:0] SEQ_ONE   = 3'd1;
  localparam logic [SEQ_W-1:0] SEQ_TWO   = 3'd2;
  localparam logic [SEQ_W-1:0] SEQ_THREE = 3'd3;
  localparam logic [SEQ_W-1:0] SEQ_FOUR  = 3'd4;
  localparam logic [SEQ_W-1:0] SEQ_FIVE  = 3'd5;
  localparam logic [SEQ_W-1:0] SEQ_SIX   = 3'd6;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd1;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_WAIT  = 2'd1,
    PH_BUZZ  = 2'd2,
    PH_RELAY = 2'd3
  } phase_t;

  typedef logic [NUM_COND-1:0][LIMIT_W-1:0] limit_arr_t;

  typedef struct packed {
    logic [SEQ_W-1:0] active_sequence;
    logic             relay_on;
    logic             buzzer_on;
  } result_t;

  function automatic logic [SECS_W-1:0] phase_duration(input logic [SEQ_W-1:0] seq,
                                                       input phase_t ph);
    logic [SECS_W-1:0] dur;
    dur = DUR_UNTIMED;
    case (ph)
      PH_WAIT: begin
        dur = (seq == SEQ_ONE) ? DUR_WAIT_ONE : DUR_WAIT;
      end
      PH_BUZZ: begin
        if (seq == SEQ_THREE || seq == SEQ_FOUR) dur = DUR_BUZZ;
        else if (seq == SEQ_FIVE || seq == SEQ_SIX) dur = DUR_BUZZ_LONG;
        else dur = DUR_UNTIMED;
      end
      PH_RELAY: begin
        dur = DUR_RELAY;
      end
      default: begin
        dur = DUR_UNTIMED;
      end
    endcase
    return dur;
  endfunction

endpackage

/* hw/rtl/cas_core.sv */
// cas_core: sequencer state (phase, sequence, seconds, repeat counts) and its one-step update
// depends on cas_pkg

module cas_core (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       step_en,
  input  logic [cas_pkg::NUM_COND-1:0]               cond_bits,
  input  logic                                       second_tick,
  input  cas_pkg::limit_arr_t                        limits,
  output cas_pkg::result_t                           result_nxt
);
  import cas_pkg::*;

  phase_t                              phase_r, phase_nxt;
  logic [SEQ_W-1:0]                    seq_r, seq_nxt;
  logic [SECS_W-1:0]                   secs_r, secs_nxt;
  logic [NUM_COND-1:0][LIMIT_W-1:0]    counts_r, counts_nxt;

  logic              found;
  logic [SEQ_W-1:0]  sel_idx;
  logic [SEQ_W-1:0]  own_idx;
  logic              own;
  logic              c2;
  logic [SECS_W-1:0] dur;
  logic [SECS_W-1:0] secs_inc;
  logic              running;

  // priority pick, bit 0 first
  always_comb begin
    found   = 1'b0;
    sel_idx = '0;
    for (int i = NUM_COND - 1; i >= 0; i--) begin
      if (cond_bits[i]) begin
        found   = 1'b1;
        sel_idx = SEQ_W'(i);
      end
    end
  end

  assign running  = (phase_r != PH_IDLE) && (seq_r >= SEQ_ONE) && (seq_r <= SEQ_SIX);
  assign own_idx  = seq_r - SEQ_ONE;
  assign own      = cond_bits[own_idx];
  assign c2       = cond_bits[1];
  assign dur      = phase_duration(seq_r, phase_r);
  assign secs_inc = (second_tick && (secs_r < SECS_MAX)) ? secs_r + 4'd1 : secs_r;

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    seq_nxt    = seq_r;
    secs_nxt   = secs_r;
    counts_nxt = counts_r;
    if (!running) begin
      phase_nxt = PH_IDLE;
      seq_nxt   = SEQ_NONE;
      secs_nxt  = '0;
      if (found && (counts_r[sel_idx] < limits[sel_idx])) begin
        for (int m = 0; m < NUM_COND; m++) begin
          counts_nxt[m] = (SEQ_W'(m) == sel_idx) ? counts_r[m] + 8'd1 : '0;
        end
        seq_nxt   = sel_idx + SEQ_ONE;
        phase_nxt = (seq_nxt == SEQ_TWO) ? PH_BUZZ : PH_WAIT;
      end
    end else if (dur == DUR_UNTIMED) begin
      if (!own) begin
        phase_nxt = PH_IDLE;
        seq_nxt   = SEQ_NONE;
        secs_nxt  = '0;
      end
    end else begin
      secs_nxt = secs_inc;
      if (secs_inc >= dur) begin
        secs_nxt = '0;
        if (phase_r == PH_WAIT) begin
          phase_nxt = PH_BUZZ;
        end else if (phase_r == PH_BUZZ && (seq_r == SEQ_THREE || seq_r == SEQ_FOUR)) begin
          phase_nxt = PH_RELAY;
        end else begin
          phase_nxt = PH_IDLE;
          seq_nxt   = SEQ_NONE;
        end
      end else if (c2 || !own) begin
        secs_nxt = '0;
        if (seq_r == SEQ_ONE) begin
          phase_nxt = PH_BUZZ;
        end else begin
          phase_nxt = PH_IDLE;
          seq_nxt   = SEQ_NONE;
        end
      end
    end
  end

  // outputs after this step
  always_comb begin
    result_nxt.buzzer_on       = (phase_nxt == PH_BUZZ);
    result_nxt.relay_on        = (phase_nxt == PH_RELAY);
    result_nxt.active_sequence = (phase_nxt == PH_IDLE) ? SEQ_NONE : seq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      seq_r    <= SEQ_NONE;
      secs_r   <= '0;
      counts_r <= '0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      seq_r    <= seq_nxt;
      secs_r   <= secs_nxt;
      counts_r <= counts_nxt;
    end
  end

endmodule

/* hw/rtl/condition_alarm_sequencer_top.sv */
// condition_alarm_sequencer_top: stream wrapper with input register, limit registers and result register
// depends on cas_pkg and cas_core
//
// One transaction in, one transaction out, at one item per clock sustained while out_tready
// is held high. An item lands in the input register, is stepped through the sequencer state
// into the result register and is presented from there; both registers advance whenever the
// result register is empty or being taken. No transaction is accepted while rst_n is low.
// Limits are written through cfg_we, cfg_index and cfg_data; the user must write them only while
// the block is idle, as the block does not enforce this; indexes above five are ignored.

module condition_alarm_sequencer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // cond_bits[5:0], second_tick[6], zero[7]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // buzzer_on[0], relay_on[1], active_sequence[4:2], zero[7:5]
  input  logic        cfg_we,
  input  logic [cas_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cas_pkg::LIMIT_W-1:0]   cfg_data
);
  import cas_pkg::*;

  logic                in_valid_r;
  logic [NUM_COND-1:0] cond_r;
  logic                tick_r;
  logic                out_valid_r;
  result_t             result_r;
  result_t             result_nxt;
  limit_arr_t          limits_r;
  logic                out_free;
  logic                step_en;

  assign out_free  = !out_valid_r || out_tready;
  assign step_en   = in_valid_r && out_free;
  assign in_tready = rst_n && (!in_valid_r || out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      cond_r <= in_tdata[NUM_COND-1:0];
      tick_r <= in_tdata[NUM_COND];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r <= {NUM_COND{LIMIT_RESET}};
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_COND))) begin
      limits_r[cfg_index] <= cfg_data;
    end
  end

  cas_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (step_en),
    .cond_bits   (cond_r),
    .second_tick (tick_r),
    .limits      (limits_r),
    .result_nxt  (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      result_r <= result_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, result_r.active_sequence, result_r.relay_on, result_r.buzzer_on};

endmodule

/* tb/cas_result_checker.sv */
// cas_result_checker: watches the input, result and limit-write ports of the alarm sequencer,
// predicts each result transaction and compares it field by field with the block
// depends on cas_pkg
module cas_result_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // cond_bits[5:0], second_tick[6], zero[7]
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [7:0]                    out_tdata,  // buzzer_on[0], relay_on[1], active_sequence[4:2]
  input  logic                          cfg_we,
  input  logic [cas_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cas_pkg::LIMIT_W-1:0]   cfg_data,
  output int                            fail_count,
  output int                            pending
);
  import cas_pkg::*;

  phase_t             ph;
  logic [SEQ_W-1:0]   seq;
  logic [SECS_W-1:0]  secs;
  logic [LIMIT_W-1:0] repeats [NUM_COND];
  logic [LIMIT_W-1:0] limits  [NUM_COND];
  result_t            expected_outputs [$];
  int                 n_fail = 0;
  int                 n_pending = 0;

  assign fail_count = n_fail;
  assign pending    = n_pending;

  task automatic report_mismatch(input string what, input int got, input int want);
    n_fail++;
    $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
  endtask

  task automatic clear_run;
    ph   = PH_IDLE;
    seq  = SEQ_NONE;
    secs = '0;
  endtask

  function automatic logic [SECS_W-1:0] timed_len(input logic [SEQ_W-1:0] s, input phase_t p);
    if (p == PH_WAIT) return (s == SEQ_ONE) ? DUR_WAIT_ONE : DUR_WAIT;
    if (p == PH_RELAY) return DUR_RELAY;
    if (p == PH_BUZZ && (s == SEQ_THREE || s == SEQ_FOUR)) return DUR_BUZZ;
    if (p == PH_BUZZ && (s == SEQ_FIVE || s == SEQ_SIX)) return DUR_BUZZ_LONG;
    return DUR_UNTIMED;
  endfunction

  task automatic step_alarm(input logic [NUM_COND-1:0] cond, input logic tick,
                            output result_t r);
    int                k;
    logic              own;
    logic              c2;
    logic [SECS_W-1:0] dur;
    if (ph == PH_IDLE || seq < SEQ_ONE || seq > SEQ_SIX) begin
      clear_run();
      k = 0;
      while (k < NUM_COND && !cond[k]) k++;
      if (k < NUM_COND && repeats[k] < limits[k]) begin
        for (int m = 0; m < NUM_COND; m++) begin
          repeats[m] = (m == k) ? repeats[m] + 1'b1 : '0;
        end
        seq = SEQ_W'(k + 1);
        ph  = (seq == SEQ_TWO) ? PH_BUZZ : PH_WAIT;
      end
    end else begin
      own = cond[seq - 1];
      c2  = cond[SEQ_TWO - 1];
      dur = timed_len(seq, ph);
      if (dur == DUR_UNTIMED) begin
        if (!own) clear_run();
      end else begin
        if (tick && secs < SECS_MAX) secs = secs + 1'b1;
        if (secs >= dur) begin
          secs = '0;
          if (ph == PH_WAIT) ph = PH_BUZZ;
          else if (ph == PH_BUZZ && (seq == SEQ_THREE || seq == SEQ_FOUR)) ph = PH_RELAY;
          else clear_run();
        end else if (c2 || !own) begin
          if (seq == SEQ_ONE) begin
            ph   = PH_BUZZ;
            secs = '0;
          end else begin
            clear_run();
          end
        end
      end
    end
    r.buzzer_on       = (ph == PH_BUZZ);
    r.relay_on        = (ph == PH_RELAY);
    r.active_sequence = (ph == PH_IDLE) ? SEQ_NONE : seq;
  endtask

  always @(posedge clk) begin : track
    result_t got;
    result_t want;
    if (!rst_n) begin
      clear_run();
      for (int m = 0; m < NUM_COND; m++) begin
        repeats[m] = '0;
        limits[m]  = LIMIT_RESET;
      end
      expected_outputs.delete();
    end else begin
      if (cfg_we && cfg_index < NUM_COND) limits[cfg_index] = cfg_data;
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[4:0]);
        if (expected_outputs.size() == 0) begin
          report_mismatch("unexpected result", out_tdata, 0);
        end else begin
          want = expected_outputs.pop_front();
          if (got.buzzer_on != want.buzzer_on)
            report_mismatch("buzzer_on", got.buzzer_on, want.buzzer_on);
          if (got.relay_on != want.relay_on)
            report_mismatch("relay_on", got.relay_on, want.relay_on);
          if (got.active_sequence != want.active_sequence)
            report_mismatch("active_sequence", got.active_sequence, want.active_sequence);
        end
      end
      if (in_tvalid && in_tready) begin
        step_alarm(in_tdata[5:0], in_tdata[6], want);
        expected_outputs.push_back(want);
      end
    end
    n_pending <= expected_outputs.size();
  end

endmodule

/* tb/tb_top.sv */
// tb_top: drives directed and random condition/tick transactions and limit writes into
// condition_alarm_sequencer_top with random idling on both sides; gives the verdict
// depends on cas_pkg, condition_alarm_sequencer_top and cas_result_checker
module tb_top;
  import cas_pkg::*;

  typedef enum int {
    LIM_ZERO,
    LIM_ONE,
    LIM_FULL,
    LIM_FEW,
    LIM_ANY,
    LIM_EXTREME
  } limit_mode_t;

  localparam int STALL_LIMIT  = 1000;
  localparam int RANDOM_ITEMS = 1850;
  localparam int NUM_PHASES   = 6;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata   = '0;   // cond_bits[5:0], second_tick[6], zero[7]
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;         // buzzer_on[0], relay_on[1], active_sequence[4:2]
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [LIMIT_W-1:0]   cfg_data   = '0;
  logic                 quiet      = 1'b0;
  int                   fail_count;
  int                   pending;
  int                   stall_cycles = 0;

  // {second_tick, cond_bits}
  logic [6:0] directed_items [25] = '{
    7'h40, 7'h7F, 7'h41, 7'h41, 7'h03, 7'h00, 7'h7F, 7'h02, 7'h02, 7'h00,
    7'h41, 7'h03, 7'h00, 7'h44, 7'h44, 7'h44, 7'h46, 7'h04, 7'h10, 7'h60,
    7'h20, 7'h22, 7'h08, 7'h48, 7'h18
  };

  always #10 clk = ~clk;

  condition_alarm_sequencer_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  cas_result_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    out_tready <= quiet || ($urandom_range(99) >= 7);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_item(input logic [NUM_COND-1:0] cb, input logic tk);
    while (!quiet && $urandom_range(99) < 7) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, tk, cb};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // indexes six and seven are written too and must be ignored
  task automatic program_limits(input limit_mode_t mode);
    logic [LIMIT_W-1:0] v;
    for (int i = 0; i < 8; i++) begin
      case (mode)
        LIM_ZERO: v = '0;
        LIM_ONE:  v = 8'd1;
        LIM_FULL: v = 8'hFF;
        LIM_FEW:  v = LIMIT_W'($urandom_range(3));
        LIM_ANY:  v = LIMIT_W'($urandom_range(255));
        default:  v = $urandom_range(1) ? 8'hFF : 8'h00;
      endcase
      if (i >= NUM_COND) v = LIMIT_W'($urandom_range(255));
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= v;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // mostly one condition held as the top priority while seconds tick, sometimes upset
  task automatic run_episode(output int count);
    int                  k;
    int                  len;
    int                  tick_pct;
    int                  upset_pct;
    logic [NUM_COND-1:0] cb;
    logic [NUM_COND-1:0] higher;
    logic                tk;
    count = 0;
    if ($urandom_range(99) < 20) begin
      len = $urandom_range(10, 1);
      repeat (len) begin
        send_item(NUM_COND'($urandom_range(63)), 1'($urandom_range(1)));
        count++;
      end
    end else begin
      k         = $urandom_range(NUM_COND - 1);
      higher    = 6'h3F << (k + 1);
      len       = $urandom_range(40, 4);
      tick_pct  = $urandom_range(100, 40);
      upset_pct = $urandom_range(1) ? 0 : $urandom_range(8, 1);
      repeat (len) begin
        cb = (NUM_COND'(1) << k) | (NUM_COND'($urandom) & higher);
        if ($urandom_range(99) < upset_pct) begin
          if ($urandom_range(1)) cb[k] = 1'b0;
          else cb[SEQ_TWO - 1] = 1'b1;
        end
        tk = ($urandom_range(99) < tick_pct);
        send_item(cb, tk);
        count++;
      end
    end
  endtask

  initial begin
    int          sent;
    int          n;
    limit_mode_t phase_modes [NUM_PHASES];
    phase_modes = '{LIM_FULL, LIM_ONE, LIM_FEW, LIM_ANY, LIM_EXTREME, LIM_FULL};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_items[i]) send_item(directed_items[i][5:0], directed_items[i][6]);
    drain();

    // zero limits: nothing may start
    program_limits(LIM_ZERO);
    send_item(6'h3F, 1'b1);
    send_item(6'h04, 1'b0);
    send_item(6'h20, 1'b1);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      program_limits(phase_modes[p]);
      quiet <= (p == 3);
      sent = 0;
      while (sent < RANDOM_ITEMS / NUM_PHASES) begin
        run_episode(n);
        sent += n;
      end
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/cas_pkg.sv
hw/rtl/cas_core.sv
hw/rtl/condition_alarm_sequencer_top.sv
tb/cas_result_checker.sv
tb/tb_top.sv
